// ===== rtl/utf8acc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8acc_pkg: shared types and constants for the accent folding block
// Item structs for both channels and the second-byte lookup for the
// Hungarian accented vowels that follow a 0xC3 lead byte.
// ----------------------------------------------------------------------------
package utf8acc_pkg;

    localparam logic [7:0] LEAD_BYTE    = 8'hC3;
    localparam logic [7:0] UNKNOWN_CHAR = 8'h3F;  // '?'

    // One input item: a raw byte and the end-of-string flag
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    // One result item: the folded character and the end-of-string flag
    typedef struct packed {
        logic [7:0] out_char;
        logic       out_last;
    } t_out_item;

    // Second byte of a C3 pair to its plain letter, '?' for anything else
    function automatic logic [7:0] map_follow(input logic [7:0] b);
        logic [7:0] c;
        case (b)
            8'hA1:   c = 8'h61;  // a acute
            8'hA9:   c = 8'h65;  // e acute
            8'hAD:   c = 8'h69;  // i acute
            8'hB3:   c = 8'h6F;  // o acute
            8'hB6:   c = 8'h6F;  // o diaeresis
            8'hB5:   c = 8'h6F;  // o double acute (as sent)
            8'hBA:   c = 8'h75;  // u acute
            8'hBC:   c = 8'h75;  // u diaeresis
            8'hBB:   c = 8'h75;  // u double acute (as sent)
            8'h81:   c = 8'h41;  // A acute
            8'h89:   c = 8'h45;  // E acute
            8'h8D:   c = 8'h49;  // I acute
            8'h93:   c = 8'h4F;  // O acute
            8'h96:   c = 8'h4F;  // O diaeresis
            8'h95:   c = 8'h4F;  // O double acute (as sent)
            8'h9A:   c = 8'h55;  // U acute
            8'h9C:   c = 8'h55;  // U diaeresis
            8'h9B:   c = 8'h55;  // U double acute (as sent)
            default: c = UNKNOWN_CHAR;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/utf8_accent_to_ascii.sv =====
`timescale 1ns / 1ps
// A result is registered in the output register, or in the skid stage on a stall.
// Throughput: one byte per cycle unless the skid is full; a single lookup stage feeds the
// output register, with a one-entry skid stage so input stays open while a result waits.
// A held 0xC3 lead byte gives no result; the item after it gives the folded character.
// Reset (synchronous, active low) clears the held lead, the output valid and the skid.
// ----------------------------------------------------------------------------
// utf8_accent_to_ascii: UTF-8 Hungarian accent folding to plain ASCII
// Holds a non-final 0xC3 lead byte and replaces the following byte by its plain letter,
// or by '?' when it is no accented vowel; all other bytes pass through unchanged.
// ----------------------------------------------------------------------------
module utf8_accent_to_ascii (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  utf8acc_pkg::t_in_item i_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output utf8acc_pkg::t_out_item o_data
);

    logic                   r_lead;
    logic                   n_lead;
    logic                   r_out_valid;
    logic                   r_skid_valid;
    utf8acc_pkg::t_out_item r_out;
    utf8acc_pkg::t_out_item r_skid;

    logic                   in_take;
    logic                   out_take;
    logic                   is_lead;
    logic                   produce;
    utf8acc_pkg::t_out_item new_item;

    // Handshakes: input closes only while the skid stage is full
    assign o_stall  = r_skid_valid;
    assign in_take  = i_valid && !o_stall;
    assign out_take = r_out_valid && !i_stall;

    // Per-item decode
    always_comb begin
        is_lead  = (i_data.in_byte == utf8acc_pkg::LEAD_BYTE) && !i_data.in_last;
        produce  = in_take && (r_lead || !is_lead);
        n_lead   = r_lead;
        if (in_take) begin
            n_lead = !r_lead && is_lead;
        end
        new_item.out_last = i_data.in_last;
        if (r_lead) begin
            new_item.out_char = utf8acc_pkg::map_follow(i_data.in_byte);
        end else begin
            new_item.out_char = i_data.in_byte;
        end
    end

    // Lead byte state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead <= 1'b0;
        end else begin
            r_lead <= n_lead;
        end
    end

    // Output register and skid stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (produce) begin
            if (r_out_valid && !out_take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output and skid payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (produce) begin
            if (r_out_valid && !out_take) begin
                r_skid <= new_item;
            end else begin
                r_out <= new_item;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // Skid stage only fills behind a held result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds an item while output register is empty");

    // Skid fills only when the output was stalled
    a_skid_fill_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && i_stall))
        else $error("skid filled without an output stall");

    // A taken non-final lead byte is held
    a_lead_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && !r_lead && is_lead) |=> r_lead)
        else $error("lead byte not held");

    // No lead survives the end of a string
    a_lead_cleared_at_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && i_data.in_last) |=> !r_lead)
        else $error("lead held across end of string");

    // A taken item after a lead always yields a result
    a_pair_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && r_lead) |-> produce)
        else $error("second byte of pair gave no result");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for utf8_accent_to_ascii
// Drives byte streams with end-of-string flags through the accent folder and
// checks every output character against a local model of the C3 pairing.
// Directed corner strings come first, then random text with accented pairs
// and raw byte noise under varying idle patterns on both sides of the block,
// and last a long output hold-off.
// ----------------------------------------------------------------------------
module tb;

    localparam int CLK_HALF       = 2;
    localparam int RESET_CYCLES   = 6;
    localparam int HOLD_OFF_LEN   = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 5;

    logic                   i_clk   = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_stall;
    utf8acc_pkg::t_in_item  i_data  = '0;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    utf8acc_pkg::t_out_item o_data;

    // Folding model state and the characters still owed by the block
    logic                   lead_held = 1'b0;
    utf8acc_pkg::t_out_item folded_due[$];

    int  error_count   = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_off_req  = 1'b0;
    int  hold_left     = 0;
    int  quiet_cycles  = 0;

    utf8_accent_to_ascii dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // Plain letter for the second byte of a C3 pair, '?' when not an accent
    function automatic logic [7:0] plain_letter(input logic [7:0] b);
        case (b)
            8'hA1: return "a";
            8'hA9: return "e";
            8'hAD: return "i";
            8'hB3, 8'hB6, 8'hB5: return "o";
            8'hBA, 8'hBC, 8'hBB: return "u";
            8'h81: return "A";
            8'h89: return "E";
            8'h8D: return "I";
            8'h93, 8'h96, 8'h95: return "O";
            8'h9A, 8'h9C, 8'h9B: return "U";
            default: return utf8acc_pkg::UNKNOWN_CHAR;
        endcase
    endfunction

    // One of the eighteen accent second bytes, by index
    function automatic logic [7:0] accent_code(input int k);
        case (k)
            0:  return 8'hA1;
            1:  return 8'hA9;
            2:  return 8'hAD;
            3:  return 8'hB3;
            4:  return 8'hB6;
            5:  return 8'hB5;
            6:  return 8'hBA;
            7:  return 8'hBC;
            8:  return 8'hBB;
            9:  return 8'h81;
            10: return 8'h89;
            11: return 8'h8D;
            12: return 8'h93;
            13: return 8'h96;
            14: return 8'h95;
            15: return 8'h9A;
            16: return 8'h9C;
            default: return 8'h9B;
        endcase
    endfunction

    // Model one accepted byte: hold a lead, fold a follower, or pass through
    task automatic fold_byte(input utf8acc_pkg::t_in_item item);
        utf8acc_pkg::t_out_item res;
        if (lead_held) begin
            lead_held    = 1'b0;
            res.out_char = plain_letter(item.in_byte);
            res.out_last = item.in_last;
            folded_due.push_back(res);
        end else if (item.in_byte == utf8acc_pkg::LEAD_BYTE && !item.in_last) begin
            lead_held = 1'b1;
        end else begin
            res.out_char = item.in_byte;
            res.out_last = item.in_last;
            folded_due.push_back(res);
        end
    endtask

    // Offer one item, with random idle cycles ahead of it, until taken
    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_data.in_byte <= b;
        i_data.in_last <= last;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Receiver: random stalls, or a long hold-off when asked
    always @(negedge i_clk) begin
        if (hold_off_req) begin
            hold_left    = HOLD_OFF_LEN;
            hold_off_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_stall  <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Predict on input acceptance first, then check the output item
    always @(posedge i_clk) begin
        utf8acc_pkg::t_out_item want;
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                fold_byte(i_data);
            if (o_valid && !i_stall) begin
                if (folded_due.size() == 0) begin
                    $display("%0t: unexpected item, got char %h last %b",
                             $time, o_data.out_char, o_data.out_last);
                    error_count++;
                end else begin
                    want = folded_due.pop_front();
                    if (o_data.out_char !== want.out_char ||
                        o_data.out_last !== want.out_last) begin
                        $display("%0t: mismatch, expected char %h last %b, got char %h last %b",
                                 $time, want.out_char, want.out_last,
                                 o_data.out_char, o_data.out_last);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles where neither channel moves an item
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Extremes, lead as last byte, lead after lead, last after lead, zero byte
    task automatic test_directed_cases();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h41, 1'b1);
        send_byte(utf8acc_pkg::LEAD_BYTE, 1'b1);
        send_byte(utf8acc_pkg::LEAD_BYTE, 1'b0);
        send_byte(8'hA1, 1'b0);
        send_byte(utf8acc_pkg::LEAD_BYTE, 1'b0);
        send_byte(utf8acc_pkg::LEAD_BYTE, 1'b0);
        send_byte(utf8acc_pkg::LEAD_BYTE, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(utf8acc_pkg::LEAD_BYTE, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(utf8acc_pkg::LEAD_BYTE, 1'b0);
        send_byte(8'h9B, 1'b1);
        // string ended, so a lone lead as last byte passes again
        send_byte(utf8acc_pkg::LEAD_BYTE, 1'b1);
        send_byte(8'h00, 1'b1);
    endtask

    // Random strings of printable text and C3 pairs, last flag on the end
    task automatic test_accent_strings(input int n_items);
        int sent;
        int len;
        bit end_on_lead;
        sent = 0;
        while (sent < n_items) begin
            len         = $urandom_range(1, 12);
            end_on_lead = ($urandom_range(0, 9) == 0);
            for (int i = 0; i < len; i++) begin
                if (end_on_lead && i == len - 1) begin
                    send_byte(utf8acc_pkg::LEAD_BYTE, 1'b1);
                    sent++;
                end else if ($urandom_range(0, 1) == 1) begin
                    send_byte(utf8acc_pkg::LEAD_BYTE, 1'b0);
                    if ($urandom_range(0, 99) < 85)
                        send_byte(accent_code($urandom_range(0, 17)), i == len - 1);
                    else
                        send_byte(8'($urandom_range(0, 255)), i == len - 1);
                    sent += 2;
                end else begin
                    send_byte(8'($urandom_range(8'h20, 8'h7E)), i == len - 1);
                    sent++;
                end
            end
        end
    endtask

    // Raw bytes with many leads and random last flags
    task automatic test_raw_bytes(input int n_items);
        logic [7:0] b;
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 3) == 0)
                b = utf8acc_pkg::LEAD_BYTE;
            else
                b = 8'($urandom_range(0, 255));
            send_byte(b, $urandom_range(0, 7) == 0);
        end
    endtask

    // Receiver holds off for a long stretch while text keeps coming
    task automatic test_output_hold_off();
        @(negedge i_clk);
        i_valid      <= 1'b0;
        hold_off_req = 1'b1;
        test_accent_strings(60);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 20;
        recv_idle_pct = 71;
        test_directed_cases();
        test_accent_strings(400);
        test_raw_bytes(100);

        send_idle_pct = 71;
        recv_idle_pct = 20;
        test_accent_strings(400);
        test_raw_bytes(100);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_accent_strings(350);
        test_raw_bytes(100);
        test_output_hold_off();

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (folded_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
